@@ design/http_host_extractor_unit_macros.svh @@
// Assertion macros shared by the host extractor RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef HTTP_HOST_EXTRACTOR_UNIT_MACROS_SVH
`define HTTP_HOST_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HHX_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HHX_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ design/hhx_pkg.sv @@
// Types and constants of the HTTP host extractor.
// No dependencies; every other design file but the assertion macros header imports this package.
package hhx_pkg;

	localparam int POS_W   = 16;
	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int LIMIT_W = 9;
	localparam int WORDS_W = 4;
	localparam int PAT_W   = 3;
	localparam int HOFS_W  = 8;

	localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 16'd16384;
	localparam logic [POS_W-1:0] POS_SAT         = 16'hFFFF;

	// Fixed header byte positions.
	localparam logic [POS_W-1:0] POS_ETYPE_HI  = 16'd12;
	localparam logic [POS_W-1:0] POS_ETYPE_LO  = 16'd13;
	localparam logic [POS_W-1:0] POS_IHL       = 16'd14;
	localparam logic [POS_W-1:0] POS_PROTO     = 16'd23;
	localparam logic [POS_W-1:0] POS_SRC_FIRST = 16'd26;
	localparam logic [POS_W-1:0] POS_SRC_LAST  = 16'd29;
	localparam logic [POS_W-1:0] POS_DST_FIRST = 16'd30;
	localparam logic [POS_W-1:0] POS_DST_LAST  = 16'd33;
	localparam logic [POS_W-1:0] POS_IP_OPT    = 16'd34;

	localparam logic [HOFS_W-1:0] ETH_HDR_BYTES = 8'd14;
	localparam logic [HOFS_W-1:0] TCP_DOFF_OFS  = 8'd12;

	localparam logic [7:0] ETYPE_HI     = 8'h08;
	localparam logic [7:0] ETYPE_LO     = 8'h00;
	localparam logic [7:0] IP_PROTO_TCP = 8'd6;
	localparam logic [7:0] NUL_BYTE     = 8'h00;
	localparam logic [WORDS_W-1:0] MIN_HDR_WORDS = 4'd5;
	localparam logic [PAT_W-1:0]   PAT_LEN       = 3'd5;

	localparam logic [PORT_W-1:0]  MATCH_PORT_RST    = 16'd80;
	localparam logic [LIMIT_W-1:0] CAPTURE_LIMIT_RST = 9'd256;

	typedef enum logic [0:0] {
		REG_MATCH_PORT    = 1'b0,
		REG_CAPTURE_LIMIT = 1'b1
	} hhx_reg_t;

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_SEARCH  = 6'b000010,
		PH_SKIP    = 6'b000100,
		PH_CAPTURE = 6'b001000,
		PH_DONE    = 6'b010000,
		PH_REJECT  = 6'b100000
	} hhx_phase_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} hhx_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] source_address;
		logic [PORT_W-1:0] source_port;
		logic [ADDR_W-1:0] dest_address;
		logic [PORT_W-1:0] dest_port;
		logic [7:0]        host_byte;
		logic              byte_valid;
		logic              record_last;
	} hhx_rec_t;

	// Characters of the "Host:" marker.
	function automatic logic [7:0] host_char(input logic [PAT_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd1:    c = 8'h6F;
			3'd2:    c = 8'h73;
			3'd3:    c = 8'h74;
			3'd4:    c = 8'h3A;
			default: c = 8'h48;
		endcase
		return c;
	endfunction

endpackage

@@ design/hhx_rx_if.sv @@
// Byte stream channel carrying frame bytes into the extractor.
// Depends on hhx_pkg.
interface hhx_rx_if;
	import hhx_pkg::*;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source(output valid, output rx_byte, output frame_end, input ready);
	modport sink(input valid, input rx_byte, input frame_end, output ready);
endinterface

@@ design/hhx_rec_if.sv @@
// Result channel carrying captured host bytes with their header fields.
// Depends on hhx_pkg.
interface hhx_rec_if;
	import hhx_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] source_address;
	logic [PORT_W-1:0] source_port;
	logic [ADDR_W-1:0] dest_address;
	logic [PORT_W-1:0] dest_port;
	logic [7:0]        host_byte;
	logic              byte_valid;
	logic              record_last;

	modport source(output valid, output source_address, output source_port,
		output dest_address, output dest_port, output host_byte,
		output byte_valid, output record_last, input ready);
	modport sink(input valid, input source_address, input source_port,
		input dest_address, input dest_port, input host_byte,
		input byte_valid, input record_last, output ready);
endinterface

@@ design/hhx_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on hhx_pkg.
interface hhx_cfg_if;
	import hhx_pkg::*;
	logic        valid;
	logic        ready;
	hhx_reg_t    index;
	logic [15:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ design/hhx_in_stage.sv @@
// Input register of the host extractor: holds one frame byte beat.
// Depends on hhx_pkg.
module hhx_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  hhx_pkg::hhx_item_t in_item,
	output logic              in_ready,
	input  logic              take,
	output logic              item_valid,
	output hhx_pkg::hhx_item_t item
);
	import hhx_pkg::*;

	logic      valid_s1;
	hhx_item_t item_s1;

	assign in_ready   = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end
endmodule

@@ design/hhx_parser.sv @@
// Frame parser: header tracking, marker search and capture per byte.
// Depends on hhx_pkg and the assertion macros header.
`include "http_host_extractor_unit_macros.svh"
module hhx_parser #(
	parameter int URL_BYTES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  hhx_pkg::hhx_item_t           item,
	input  logic [hhx_pkg::PORT_W-1:0]   match_port,
	input  logic [hhx_pkg::LIMIT_W-1:0]  capture_limit,
	output hhx_pkg::hhx_rec_t            rec,
	output logic                         rec_valid
);
	import hhx_pkg::*;

	localparam int URL_W = $clog2(URL_BYTES + 1);
	localparam int CMP_W = (URL_W > LIMIT_W) ? URL_W : LIMIT_W;

	logic [POS_W-1:0]   pos_q;
	logic [WORDS_W-1:0] ihl_q, doff_q, ihl_u, doff_u;
	logic [ADDR_W-1:0]  src_addr_q, dst_addr_q, src_addr_u, dst_addr_u;
	logic [PORT_W-1:0]  src_port_q, dst_port_q, src_port_u, dst_port_u;
	hhx_phase_t         phase_q, phase_u;
	logic [PAT_W-1:0]   pat_q, pat_u;
	logic [LIMIT_W-1:0] cnt_q, cnt_u, cap;

	logic [CMP_W-1:0]   limit_ext, url_c;
	logic [HOFS_W-1:0]  t_base, t_doff, t_end;
	logic [7:0]         b;
	logic               byte_out, empty_out;

	assign b         = item.rx_byte;
	assign limit_ext = CMP_W'(capture_limit);
	assign url_c     = CMP_W'(URL_BYTES);
	assign cap       = (limit_ext < url_c) ? capture_limit : url_c[LIMIT_W-1:0];

	// TCP header start and last TCP header byte.
	assign t_base = ETH_HDR_BYTES + {2'b00, ihl_q, 2'b00};
	assign t_doff = t_base + TCP_DOFF_OFS;
	assign t_end  = t_base + {2'b00, doff_q, 2'b00} - 8'd1;

	always_comb begin
		ihl_u      = ihl_q;
		doff_u     = doff_q;
		src_addr_u = src_addr_q;
		dst_addr_u = dst_addr_q;
		src_port_u = src_port_q;
		dst_port_u = dst_port_q;
		phase_u    = phase_q;
		pat_u      = pat_q;
		cnt_u      = cnt_q;
		byte_out   = 1'b0;
		if (pos_q < MAX_FRAME_BYTES) begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_ETYPE_HI) begin
						if (b != ETYPE_HI) phase_u = PH_REJECT;
					end else if (pos_q == POS_ETYPE_LO) begin
						if (b != ETYPE_LO) phase_u = PH_REJECT;
					end else if (pos_q == POS_IHL) begin
						ihl_u = b[3:0];
						if (b[3:0] < MIN_HDR_WORDS) phase_u = PH_REJECT;
					end else if (pos_q == POS_PROTO) begin
						if (b != IP_PROTO_TCP) phase_u = PH_REJECT;
					end else if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) begin
						src_addr_u = {src_addr_q[ADDR_W-9:0], b};
					end else if (pos_q >= POS_DST_FIRST && pos_q <= POS_DST_LAST) begin
						dst_addr_u = {dst_addr_q[ADDR_W-9:0], b};
					end else if (pos_q >= POS_IP_OPT) begin
						if (pos_q == {8'h00, t_base} || pos_q == {8'h00, t_base + 8'd1}) begin
							src_port_u = {src_port_q[7:0], b};
						end else if (pos_q == {8'h00, t_base + 8'd2} ||
							pos_q == {8'h00, t_base + 8'd3}) begin
							dst_port_u = {dst_port_q[7:0], b};
							if (pos_q == {8'h00, t_base + 8'd3} && dst_port_u != match_port)
								phase_u = PH_REJECT;
						end else if (pos_q == {8'h00, t_doff}) begin
							doff_u = b[7:4];
							if (b[7:4] < MIN_HDR_WORDS) phase_u = PH_REJECT;
						end else if (pos_q > {8'h00, t_doff} && pos_q == {8'h00, t_end}) begin
							phase_u = PH_SEARCH;
						end
					end
				end
				PH_SEARCH: begin
					if (b == NUL_BYTE) begin
						phase_u = PH_REJECT;
					end else if (b == host_char((pat_q < PAT_LEN) ? pat_q : 3'd0)) begin
						pat_u = pat_q + 3'd1;
						if (pat_u >= PAT_LEN) begin
							pat_u   = 3'd0;
							phase_u = PH_SKIP;
						end
					end else begin
						pat_u = (b == host_char(3'd0)) ? 3'd1 : 3'd0;
					end
				end
				PH_SKIP: phase_u = PH_CAPTURE;
				PH_CAPTURE: begin
					if (cnt_q < cap) begin
						cnt_u    = cnt_q + 9'd1;
						byte_out = 1'b1;
						if (cnt_u >= cap) phase_u = PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	// Empty record: match seen, nothing captured, frame ends here.
	assign empty_out = item.frame_end && !byte_out && cnt_u == '0 &&
		(phase_u == PH_SKIP || phase_u == PH_CAPTURE || phase_u == PH_DONE);

	always_comb begin
		rec.source_address = src_addr_u;
		rec.source_port    = src_port_u;
		rec.dest_address   = dst_addr_u;
		rec.dest_port      = dst_port_u;
		rec.host_byte      = byte_out ? b : 8'h00;
		rec.byte_valid     = byte_out;
		rec.record_last    = empty_out || (byte_out && (cnt_u >= cap || item.frame_end));
		rec_valid          = byte_out || empty_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ihl_q      <= '0;
			doff_q     <= '0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
			phase_q    <= PH_HEADER;
			pat_q      <= '0;
			cnt_q      <= '0;
		end else if (advance) begin
			if (item.frame_end) begin
				pos_q      <= '0;
				ihl_q      <= '0;
				doff_q     <= '0;
				src_addr_q <= '0;
				dst_addr_q <= '0;
				src_port_q <= '0;
				dst_port_q <= '0;
				phase_q    <= PH_HEADER;
				pat_q      <= '0;
				cnt_q      <= '0;
			end else begin
				if (pos_q != POS_SAT) pos_q <= pos_q + 16'd1;
				ihl_q      <= ihl_u;
				doff_q     <= doff_u;
				src_addr_q <= src_addr_u;
				dst_addr_q <= dst_addr_u;
				src_port_q <= src_port_u;
				dst_port_q <= dst_port_u;
				phase_q    <= phase_u;
				pat_q      <= pat_u;
				cnt_q      <= cnt_u;
			end
		end
	end

	`HHX_ASSERT_IMP(a_pat_in_search, pat_q != '0, phase_q == PH_SEARCH || phase_q == PH_REJECT, "marker progress outside search")
	`HHX_ASSERT_IMP(a_cnt_in_capture, cnt_q != '0, phase_q == PH_CAPTURE || phase_q == PH_DONE, "capture count outside capture")
	`HHX_ASSERT_NXT(a_end_clears, advance && item.frame_end, pos_q == '0 && phase_q == PH_HEADER, "frame state not cleared at frame end")
endmodule

@@ design/hhx_out_stage.sv @@
// Result register of the host extractor: holds one result beat.
// Depends on hhx_pkg.
module hhx_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  hhx_pkg::hhx_rec_t rec_in,
	input  logic              rec_in_valid,
	input  logic              out_ready,
	output logic              out_valid,
	output hhx_pkg::hhx_rec_t rec_out,
	output logic              free
);
	import hhx_pkg::*;

	logic     valid_s2;
	hhx_rec_t rec_s2;

	assign free      = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign rec_out   = rec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= rec_in_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && rec_in_valid) begin
			rec_s2 <= rec_in;
		end
	end
endmodule

@@ design/http_host_extractor_unit.sv @@
// HTTP host extractor top level: channels, configuration registers, stages.
// Depends on hhx_pkg, the channel interfaces, hhx_in_stage, hhx_parser,
// hhx_out_stage and the assertion macros header.
//
//   channel | direction | payload                                      | beat
//   --------+-----------+----------------------------------------------+-----------------
//   rx      | in        | rx_byte, frame_end                           | one frame byte
//   rec     | out       | addresses, ports, host_byte, byte_valid, last | zero or one/byte
//   cfg     | in        | index (match_port, capture_limit), data      | one register write
//
// One byte beat per cycle sustained while rec is taken; a result passes from the input
// register through the parse logic into the result register.
// The parse step is a single pass of compares per byte.
// Reset clears the frame state, the stage valids and the configuration
// registers (match_port 80, capture_limit 256); no clearing pass is needed.
// A stalled result register holds the byte in the input register; rx ready
// drops only while both stages are full and rec is not taken.
`include "http_host_extractor_unit_macros.svh"
module http_host_extractor_unit #(
	parameter int URL_BYTES = 256
) (
	input logic      clk,
	input logic      arst_n,
	hhx_rx_if.sink   rx,
	hhx_rec_if.source rec,
	hhx_cfg_if.sink  cfg
);
	import hhx_pkg::*;

	logic [PORT_W-1:0]  match_port_q;
	logic [LIMIT_W-1:0] capture_limit_q;

	hhx_item_t in_item, item;
	hhx_rec_t  rec_next, rec_out;
	logic      item_valid, take, free, rec_next_valid;

	// Register writes: always accept, ignore nothing in range.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_port_q    <= MATCH_PORT_RST;
			capture_limit_q <= CAPTURE_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MATCH_PORT:    match_port_q    <= cfg.data;
				REG_CAPTURE_LIMIT: capture_limit_q <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_item.rx_byte   = rx.rx_byte;
	assign in_item.frame_end = rx.frame_end;

	// Advance the held byte whenever the result register can take its outcome.
	assign take = item_valid && free;

	hhx_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rx.valid),
		.in_item    (in_item),
		.in_ready   (rx.ready),
		.take       (take),
		.item_valid (item_valid),
		.item       (item)
	);

	hhx_parser #(
		.URL_BYTES (URL_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (take),
		.item          (item),
		.match_port    (match_port_q),
		.capture_limit (capture_limit_q),
		.rec           (rec_next),
		.rec_valid     (rec_next_valid)
	);

	hhx_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.rec_in       (rec_next),
		.rec_in_valid (rec_next_valid),
		.out_ready    (rec.ready),
		.out_valid    (rec.valid),
		.rec_out      (rec_out),
		.free         (free)
	);

	assign rec.source_address = rec_out.source_address;
	assign rec.source_port    = rec_out.source_port;
	assign rec.dest_address   = rec_out.dest_address;
	assign rec.dest_port      = rec_out.dest_port;
	assign rec.host_byte      = rec_out.host_byte;
	assign rec.byte_valid     = rec_out.byte_valid;
	assign rec.record_last    = rec_out.record_last;

	`HHX_ASSERT_IMP(a_empty_is_last, rec.valid && !rec.byte_valid, rec.record_last && rec.host_byte == 8'h00, "empty record not marked last")
	`HHX_ASSERT_NXT(a_s1_hold, item_valid && rec.valid && !rec.ready, item_valid, "held byte dropped during result stall")
	`HHX_ASSERT_NXT(a_rec_hold, rec.valid && !rec.ready, rec.valid, "result beat dropped while stalled")
endmodule
